FILE: rtl/skt_pkg.sv
// skt_pkg: shared types, codes and default sizes for the sorted key table
// no dependencies; imported by every module of the block
package skt_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	localparam logic [1:0] CMD_FIND   = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NO_RECORD = 2'd1,
		STS_DUPLICATE = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] found_value;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

FILE: rtl/skt_cell.sv
// skt_cell: one slot of the sorted chain, holds a key/value pair and
// compares, shifts up on insert or shifts down on delete; uses skt_pkg
module skt_cell #(
	parameter int KEY_BITS   = skt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = skt_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  skt_pkg::cell_ctl_t    ctl,
	input  logic                  occupied,
	input  logic [KEY_BITS-1:0]   probe_key,
	input  logic [KEY_BITS-1:0]   new_key,
	input  logic [VALUE_BITS-1:0] new_value,
	input  logic                  prev_lt,
	input  logic [KEY_BITS-1:0]   prev_key,
	input  logic [VALUE_BITS-1:0] prev_value,
	input  logic [KEY_BITS-1:0]   next_key,
	input  logic [VALUE_BITS-1:0] next_value,
	output logic                  lt,
	output logic                  eq,
	output logic [KEY_BITS-1:0]   key,
	output logic [VALUE_BITS-1:0] value
);
	import skt_pkg::*;

	logic                  lt_q;
	logic                  eq_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			lt_q <= occupied && (key_q < probe_key);
			eq_q <= occupied && (key_q == probe_key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_q) begin
			if (prev_lt) begin
				key_q   <= new_key;
				value_q <= new_value;
			end else begin
				key_q   <= prev_key;
				value_q <= prev_value;
			end
		end else if (ctl.del && !lt_q) begin
			key_q   <= next_key;
			value_q <= next_value;
		end
	end

	assign lt    = lt_q;
	assign eq    = eq_q;
	assign key   = key_q;
	assign value = value_q;

endmodule

FILE: rtl/sorted_key_table_core.sv
// Sorted key/value table built as a chain of compare-and-shift cells.
// Uses skt_pkg and skt_cell.
//
// Requests (cmd, key, value) arrive on req with req_valid/req_stall; one
// response (status, found_value, entry_count) leaves on rsp with
// rsp_valid/rsp_stall for every request, in order.
// Cycle of acceptance: every cell compares its key with the request key.
// Update state: hit and insert position come from the registered compare
// flags; once the response register is free the cells shift up or down
// together, the response is registered and rsp_valid rises. No new
// request is taken until the update of the last one is done.
// A stalled response keeps its value; the next request can still be taken
// but its update waits until the response register frees up.
// Reset empties the table (entry count zero) and clears both handshakes;
// cell contents are not cleared, slots past the count are never used.
module sorted_key_table_core #(
	parameter int CAPACITY   = skt_pkg::CAPACITY_DEF,
	parameter int KEY_BITS   = skt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = skt_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  skt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output skt_pkg::rsp_t rsp
);
	import skt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic {
		ST_IDLE,
		ST_UPD
	} state_t;

	state_t                state_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	logic [CNT_W-1:0]      count_q;

	logic [1:0]            cmd_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;

	logic                  accept;
	logic                  out_free;
	logic                  fire;
	logic                  hit;
	logic                  full;
	cell_ctl_t             ctl;
	status_t               status;
	logic [CNT_W-1:0]      count_next;
	logic [VALUE_BITS-1:0] match_value;

	logic [KEY_BITS+KEY_W-1:0]     key_ext;
	logic [VALUE_BITS+VALUE_W-1:0] value_ext;
	logic [VALUE_BITS+VALUE_W-1:0] found_ext;
	logic [CNT_W+COUNT_W-1:0]      count_ext;
	logic [KEY_BITS-1:0]           probe_key;
	logic [VALUE_BITS-1:0]         probe_value;

	logic [CAPACITY-1:0]   lt_vec;
	logic [CAPACITY-1:0]   eq_vec;
	logic [KEY_BITS-1:0]   key_arr   [CAPACITY];
	logic [VALUE_BITS-1:0] value_arr [CAPACITY];

	assign key_ext     = {{KEY_BITS{1'b0}}, req.key};
	assign value_ext   = {{VALUE_BITS{1'b0}}, req.value};
	assign probe_key   = key_ext[KEY_BITS-1:0];
	assign probe_value = value_ext[VALUE_BITS-1:0];

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign fire      = (state_q == ST_UPD) && out_free;

	assign hit  = |eq_vec;
	assign full = (count_q >= CNT_W'(CAPACITY));

	always_comb begin
		ctl.cmp = accept;
		ctl.ins = fire && (cmd_s1 == CMD_INSERT) && !full && !hit;
		ctl.del = fire && (cmd_s1 == CMD_DELETE) && hit;
	end

	// chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  prev_lt;
		logic [KEY_BITS-1:0]   prev_key;
		logic [VALUE_BITS-1:0] prev_value;
		logic [KEY_BITS-1:0]   next_key;
		logic [VALUE_BITS-1:0] next_value;

		if (i == 0) begin : g_first
			assign prev_lt    = 1'b1;
			assign prev_key   = key_arr[i];
			assign prev_value = value_arr[i];
		end else begin : g_mid
			assign prev_lt    = lt_vec[i-1];
			assign prev_key   = key_arr[i-1];
			assign prev_value = value_arr[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_key   = key_arr[i];
			assign next_value = value_arr[i];
		end else begin : g_inner
			assign next_key   = key_arr[i+1];
			assign next_value = value_arr[i+1];
		end

		skt_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (CNT_W'(i) < count_q),
			.probe_key  (probe_key),
			.new_key    (key_s1),
			.new_value  (value_s1),
			.prev_lt    (prev_lt),
			.prev_key   (prev_key),
			.prev_value (prev_value),
			.next_key   (next_key),
			.next_value (next_value),
			.lt         (lt_vec[i]),
			.eq         (eq_vec[i]),
			.key        (key_arr[i]),
			.value      (value_arr[i])
		);
	end

	always_comb begin
		match_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (eq_vec[i]) begin
				match_value = match_value | value_arr[i];
			end
		end
	end

	always_comb begin
		status     = STS_NO_RECORD;
		count_next = count_q;
		unique case (cmd_s1)
			CMD_FIND: begin
				if (hit) begin
					status = STS_OK;
				end
			end
			CMD_INSERT: begin
				if (full) begin
					status = STS_FULL;
				end else if (hit) begin
					status = STS_DUPLICATE;
				end else begin
					status     = STS_OK;
					count_next = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (hit) begin
					status     = STS_OK;
					count_next = count_q - CNT_W'(1);
				end
			end
			default: begin
				status = STS_NO_RECORD;
			end
		endcase
	end

	assign found_ext = {{VALUE_W{1'b0}},
		((cmd_s1 == CMD_FIND) && hit) ? match_value : {VALUE_BITS{1'b0}}};
	assign count_ext = {{COUNT_W{1'b0}}, count_next};

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= req.cmd;
			key_s1   <= probe_key;
			value_s1 <= probe_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (out_free) begin
						rsp_q.status      <= status;
						rsp_q.found_value <= found_ext[VALUE_W-1:0];
						rsp_q.entry_count <= count_ext[COUNT_W-1:0];
						count_q           <= count_next;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/skt_checker.sv
// skt_checker: port-level checks on the sorted key table's handshakes
// uses skt_pkg; bound to sorted_key_table_core below
module skt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input skt_pkg::rsp_t rsp
);
	import skt_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// one request in flight: the cycle after an accept takes nothing
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while busy");

	// a new response leaves the block ready for the next request
	a_rsp_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !req_stall)
		else $error("still busy after response");

	// value only reported on success
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STS_OK) |-> (rsp.found_value == '0))
		else $error("value on failed request");

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (.*);
